@@ sv/run_length_record_replay_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the run-length record and replay block
// Each macro expects clk and rst to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef RUN_LENGTH_RECORD_REPLAY_TOP_MACROS_SVH
`define RUN_LENGTH_RECORD_REPLAY_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLRR_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RLRR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

@@ sv/rlrr_pkg.sv @@
// ---------------------------------------------------------------------------
// rlrr_pkg
// Shared types, operation codes and default sizes for the record/replay block.
// ---------------------------------------------------------------------------
`default_nettype none

package rlrr_pkg;

  localparam int CODE_BITS           = 8;
  localparam int OP_BITS             = 2;
  localparam int DEFAULT_TABLE_DEPTH = 16;
  localparam int DEFAULT_COUNT_BITS  = 16;

  localparam logic [OP_BITS-1:0] OP_RECORD = 2'd0;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_START  = 2'd2;
  localparam logic [OP_BITS-1:0] OP_FETCH  = 2'd3;

  typedef struct packed {
    logic [OP_BITS-1:0]   operation;
    logic [CODE_BITS-1:0] code_value;
  } cmd_word_t;

  typedef struct packed {
    logic                 play_valid;
    logic [CODE_BITS-1:0] play_value;
    logic                 table_full;
  } result_word_t;

  // Control strobes from the sequencer to the table memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } tbl_cmd_t;

endpackage

`default_nettype wire

@@ sv/run_length_record_replay_top.sv @@
// ---------------------------------------------------------------------------
// run_length_record_replay_top
// Run-length record and replay table with valid/ready command and result words.
// ---------------------------------------------------------------------------
// Each command word yields exactly one result word. Record appends a byte
// code to a table of TABLE_DEPTH run-length entries (code plus a saturating
// COUNT_BITS-bit repeat count), clear empties the table and stops playback,
// start rewinds playback to the first entry, and fetch returns the next
// replayed code, each entry being played exactly as often as its count.
// The table lives in a single-port-write, single-port-read memory with a
// registered read. Record, and fetch during playback, read the table when
// accepted and act on the entry in the execute state, which produces the
// result; a fetch that steps on to the next entry needs a second table read
// and produces its result in S_FETCH2. Only one command is in flight
// at a time, so table reads never overlap a pending write to the same entry.
// Results leave through an output register, and a new command is taken
// while an earlier result is still waiting there. There is no clearing pass
// after reset: only the first entry has a reset value, held by a flag.
// ---------------------------------------------------------------------------
`default_nettype none

module run_length_record_replay_top #(
  parameter int TABLE_DEPTH = rlrr_pkg::DEFAULT_TABLE_DEPTH,
  parameter int COUNT_BITS  = rlrr_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_ready,
  input  rlrr_pkg::cmd_word_t    cmd,
  output logic                   result_valid,
  input  logic                   result_ready,
  output rlrr_pkg::result_word_t result
);
  import rlrr_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);

  tbl_cmd_t              tbl;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [CODE_BITS-1:0]  wr_code;
  logic [COUNT_BITS-1:0] wr_count;
  logic [CODE_BITS-1:0]  rd_code;
  logic [COUNT_BITS-1:0] rd_count;
  logic                  slot_free;
  logic                  push;
  result_word_t          push_word;

  // The output register is free when empty or being emptied this cycle.
  assign slot_free = !result_valid || result_ready;

  rlrr_ctrl #(
    .DEPTH      (TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .tbl       (tbl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_code   (wr_code),
    .wr_count  (wr_count),
    .rd_code   (rd_code),
    .rd_count  (rd_count),
    .slot_free (slot_free),
    .push      (push),
    .push_word (push_word)
  );

  rlrr_table #(
    .DEPTH      (TABLE_DEPTH),
    .COUNT_BITS (COUNT_BITS)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .tbl      (tbl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_code  (wr_code),
    .wr_count (wr_count),
    .rd_code  (rd_code),
    .rd_count (rd_count)
  );

  // Result register: loaded when the sequencer hands over a word, emptied
  // when the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (push) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      result <= push_word;
    end
  end

endmodule

`default_nettype wire

@@ sv/rlrr_table.sv @@
// ---------------------------------------------------------------------------
// rlrr_table
// Run-length table memory: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rlrr_table #(
  parameter int DEPTH      = rlrr_pkg::DEFAULT_TABLE_DEPTH,
  parameter int COUNT_BITS = rlrr_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rlrr_pkg::tbl_cmd_t             tbl,
  input  logic [$clog2(DEPTH)-1:0]       rd_addr,
  input  logic [$clog2(DEPTH)-1:0]       wr_addr,
  input  logic [rlrr_pkg::CODE_BITS-1:0] wr_code,
  input  logic [COUNT_BITS-1:0]          wr_count,
  output logic [rlrr_pkg::CODE_BITS-1:0] rd_code,
  output logic [COUNT_BITS-1:0]          rd_count
);
  import rlrr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int EW = CODE_BITS + COUNT_BITS;

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_q;
  logic          rd_blank;
  logic          first_written;

  always_ff @(posedge clk) begin
    if (tbl.wr_en) begin
      mem[wr_addr] <= {wr_code, wr_count};
    end
    if (tbl.rd_en) begin
      rd_q     <= mem[rd_addr];
      rd_blank <= (rd_addr == AW'(0)) && !first_written;
    end
  end

  // Only the first entry has a defined reset value; it reads as empty
  // until something has been written to it.
  always_ff @(posedge clk) begin
    if (rst) begin
      first_written <= 1'b0;
    end else if (tbl.clear) begin
      first_written <= 1'b0;
    end else if (tbl.wr_en && (wr_addr == AW'(0))) begin
      first_written <= 1'b1;
    end
  end

  assign rd_code  = rd_blank ? '0 : rd_q[EW-1:COUNT_BITS];
  assign rd_count = rd_blank ? '0 : rd_q[COUNT_BITS-1:0];

endmodule

`default_nettype wire

@@ sv/rlrr_ctrl.sv @@
// ---------------------------------------------------------------------------
// rlrr_ctrl
// Sequencer: reads the table, applies record or fetch, writes back.
// ---------------------------------------------------------------------------
`default_nettype none
`include "run_length_record_replay_top_macros.svh"

module rlrr_ctrl #(
  parameter int DEPTH      = rlrr_pkg::DEFAULT_TABLE_DEPTH,
  parameter int COUNT_BITS = rlrr_pkg::DEFAULT_COUNT_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  rlrr_pkg::cmd_word_t            cmd,
  output rlrr_pkg::tbl_cmd_t             tbl,
  output logic [$clog2(DEPTH)-1:0]       rd_addr,
  output logic [$clog2(DEPTH)-1:0]       wr_addr,
  output logic [rlrr_pkg::CODE_BITS-1:0] wr_code,
  output logic [COUNT_BITS-1:0]          wr_count,
  input  logic [rlrr_pkg::CODE_BITS-1:0] rd_code,
  input  logic [COUNT_BITS-1:0]          rd_count,
  input  logic                           slot_free,
  output logic                           push,
  output rlrr_pkg::result_word_t         push_word
);
  import rlrr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int PW = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_FETCH2 = 2'd2;
  localparam logic [1:0] S_HOLD   = 2'd3;

  logic [1:0]            state, state_next;
  logic [OP_BITS-1:0]    op_q;
  logic [CODE_BITS-1:0]  val_q;
  logic [AW-1:0]         last_entry;
  logic [PW-1:0]         play_entry;
  logic [COUNT_BITS-1:0] play_repeat;
  logic                  playing;
  result_word_t          res_q;

  logic                  accept;
  logic                  code_hit;
  logic                  at_last;
  logic [AW-1:0]         rec_target;
  logic                  adv;
  logic [PW-1:0]         pe_next;
  logic                  still;
  logic                  finish;
  result_word_t          res_comb;

  assign cmd_ready = (state == S_IDLE);
  assign accept    = cmd_valid && cmd_ready;

  // Record path
  assign code_hit   = (rd_code == val_q);
  assign at_last    = (last_entry == AW'(DEPTH - 1));
  assign rec_target = (rd_code != '0) ? last_entry + AW'(1) : last_entry;

  // Fetch path: move on once the current entry has been played out
  assign adv     = playing && (play_entry < PW'(DEPTH)) && (play_repeat >= rd_count);
  assign pe_next = adv ? play_entry + PW'(1) : play_entry;
  assign still   = playing && (pe_next <= PW'(last_entry)) && (pe_next < PW'(DEPTH));

  assign finish = ((state == S_EXEC) && !((op_q == OP_FETCH) && adv && still))
                || (state == S_FETCH2);

  always_comb begin
    tbl      = '0;
    rd_addr  = last_entry;
    wr_addr  = last_entry;
    wr_code  = val_q;
    wr_count = COUNT_BITS'(1);
    res_comb = '0;
    if (state == S_IDLE) begin
      tbl.rd_en = accept && ((cmd.operation == OP_RECORD)
                          || ((cmd.operation == OP_FETCH) && playing));
      rd_addr   = (cmd.operation == OP_FETCH) ? play_entry[AW-1:0] : last_entry;
    end else if (state == S_EXEC) begin
      case (op_q)
        OP_RECORD: begin
          if (code_hit) begin
            tbl.wr_en = 1'b1;
            wr_code   = rd_code;
            wr_count  = (rd_count == '1) ? rd_count : rd_count + COUNT_BITS'(1);
          end else if (!at_last) begin
            tbl.wr_en = 1'b1;
            wr_addr   = rec_target;
          end else begin
            res_comb.table_full = 1'b1;
          end
        end
        OP_CLEAR: begin
          tbl.clear = 1'b1;
        end
        OP_FETCH: begin
          if (adv && still) begin
            tbl.rd_en = 1'b1;
            rd_addr   = pe_next[AW-1:0];
          end else if (still) begin
            res_comb.play_valid = 1'b1;
            res_comb.play_value = rd_code;
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_FETCH2) begin
      res_comb.play_valid = 1'b1;
      res_comb.play_value = rd_code;
    end
  end

  assign push      = (finish || (state == S_HOLD)) && slot_free;
  assign push_word = (state == S_HOLD) ? res_q : res_comb;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_EXEC;
      S_EXEC:   if (!finish) state_next = S_FETCH2;
                else state_next = slot_free ? S_IDLE : S_HOLD;
      S_FETCH2: state_next = slot_free ? S_IDLE : S_HOLD;
      S_HOLD:   if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_entry  <= '0;
      play_entry  <= '0;
      play_repeat <= '0;
      playing     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_EXEC) begin
        case (op_q)
          OP_RECORD: begin
            if (!code_hit && !at_last) begin
              last_entry <= rec_target;
            end
          end
          OP_CLEAR: begin
            last_entry <= '0;
            playing    <= 1'b0;
          end
          OP_START: begin
            playing     <= 1'b1;
            play_entry  <= '0;
            play_repeat <= '0;
          end
          default: begin
            play_entry <= pe_next;
            playing    <= still;
            if (!still) begin
              play_repeat <= adv ? '0 : play_repeat;
            end else if (adv) begin
              play_repeat <= COUNT_BITS'(1);
            end else begin
              play_repeat <= play_repeat + COUNT_BITS'(1);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= cmd.operation;
      val_q <= cmd.code_value;
    end
    if (finish && !slot_free) begin
      res_q <= res_comb;
    end
  end

  `RLRR_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "accepted word did not reach execute")
  `RLRR_ASSERT_SAME(a_play_in_table, playing, play_entry <= PW'(last_entry), "playback past table end")
  `RLRR_ASSERT_SAME(a_write_record, tbl.wr_en, (state == S_EXEC) && (op_q == OP_RECORD), "stray table write")
  `RLRR_ASSERT_SAME(a_fetch2_playing, state == S_FETCH2, playing && (op_q == OP_FETCH), "second read outside playback")

endmodule

`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives command words into the run-length record and replay block and checks
// every result word against a cycle-free model of the table held here.
// ---------------------------------------------------------------------------
// The test tasks run in turn from one initial block. They all go through
// send_word, which offers a command word, waits for the handshake and then
// works out the result word the block owes for it. Those predictions wait
// in awaited_results until the checking process meets the matching result.
// A separate receiver process throttles result_ready, and can be told to
// hold off for a long stretch so that the block backs up and stalls its
// command input. A free-running cycle counter ends a run that has hung.
// ---------------------------------------------------------------------------

module testbench;
  import rlrr_pkg::*;

  localparam int DEPTH        = DEFAULT_TABLE_DEPTH;
  localparam int CBITS        = DEFAULT_COUNT_BITS;
  localparam int LONG_RUN     = 150;
  localparam int RANDOM_WORDS = 1330;
  // Worst correct run: about 1700 words with full idling on both sides, plus
  // one long hold-off. Taken several times over.
  localparam int CYCLE_LIMIT  = 150_000;
  localparam int DRAIN_CYCLES = 20;

  logic         clk;
  logic         rst          = 1'b1;
  logic         cmd_valid    = 1'b0;
  logic         cmd_ready;
  cmd_word_t    cmd          = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_word_t result;

  // When clear, both sides run flat out with no gaps.
  bit          idle_on       = 1'b1;
  // A non-zero value asks the receiver for one long hold-off of that many cycles.
  int          hold_request  = 0;
  int unsigned words_sent    = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count   = 0;

  result_word_t awaited_results[$];

  // Our own copy of the run-length table and the playback position.
  logic [CODE_BITS-1:0] tbl_code  [DEPTH];
  logic [CBITS-1:0]     tbl_count [DEPTH];
  int                   cur_entry;
  int                   replay_idx;
  int                   replay_done;
  bit                   replay_on;

  run_length_record_replay_top #(
    .TABLE_DEPTH(DEPTH),
    .COUNT_BITS (CBITS)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a run that outlives the limit has lost a word somewhere.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[run_length_record_replay_top] ERROR");
    $finish;
  end

  task automatic note_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic void table_reset();
    for (int i = 0; i < DEPTH; i++) begin
      tbl_code[i]  = '0;
      tbl_count[i] = '0;
    end
    cur_entry   = 0;
    replay_idx  = 0;
    replay_done = 0;
    replay_on   = 1'b0;
  endfunction

  // Applies one command word to the model and returns the result word owed.
  function automatic result_word_t table_step(input cmd_word_t w);
    result_word_t r;
    int           slot;
    r = '0;
    case (w.operation)
      OP_RECORD: begin
        slot = cur_entry;
        if (tbl_code[slot] == w.code_value) begin
          // The same code again lengthens the run, up to the count's ceiling.
          if (tbl_count[slot] != '1) tbl_count[slot] = tbl_count[slot] + 1'b1;
        end else if (slot < DEPTH - 1) begin
          // An empty current entry (code zero) is reused rather than skipped.
          if (tbl_code[slot] != '0) slot++;
          tbl_code[slot]  = w.code_value;
          tbl_count[slot] = CBITS'(1);
          cur_entry       = slot;
        end else begin
          r.table_full = 1'b1;
        end
      end
      OP_CLEAR: begin
        cur_entry    = 0;
        tbl_code[0]  = '0;
        tbl_count[0] = '0;
        replay_on    = 1'b0;
      end
      OP_START: begin
        replay_on   = 1'b1;
        replay_idx  = 0;
        replay_done = 0;
      end
      default: begin
        if (replay_on && replay_idx < DEPTH && replay_done >= int'(tbl_count[replay_idx])) begin
          replay_idx++;
          replay_done = 0;
        end
        if (replay_idx > cur_entry || replay_idx >= DEPTH) replay_on = 1'b0;
        if (replay_on) begin
          replay_done++;
          r.play_valid = 1'b1;
          r.play_value = tbl_code[replay_idx];
        end
      end
    endcase
    return r;
  endfunction

  // Offers one command word and returns at the edge where it is taken, with
  // valid still high. The next call either keeps it high or lowers it first.
  task automatic send_word(input logic [OP_BITS-1:0] op, input logic [CODE_BITS-1:0] code);
    cmd_word_t w;
    int        gap;
    w.operation  = op;
    w.code_value = code;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= w;
    do @(posedge clk); while (!cmd_ready);
    awaited_results.push_back(table_step(w));
    words_sent++;
  endtask

  // Lowers valid before any wait that does not go through send_word.
  task automatic park_sender();
    cmd_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Codes from a small pool repeat often enough to build runs; the rest
  // are fully random so that every bit of the code is exercised.
  function automatic logic [CODE_BITS-1:0] pick_code();
    if ($urandom_range(0, 1) == 0) return CODE_BITS'($urandom_range(0, 255));
    case ($urandom_range(0, 4))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return CODE_BITS'($urandom_range(2, 5));
    endcase
  endfunction

  // Receiver: a fresh stall before every result word, or one long hold-off
  // when the pressure test asks for it.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 6) : 0;
      if (hold_request > 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall > 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ready <= 1'b1;
      do @(posedge clk); while (!result_valid);
    end
  end

  // Every accepted result word is matched against the oldest prediction.
  always @(posedge clk) begin : check_results
    result_word_t want;
    if (!rst && result_valid && result_ready) begin
      if (awaited_results.size() == 0) begin
        note_mismatch($sformatf("result word %h arrived with none awaited", result));
      end else begin
        want = awaited_results.pop_front();
        if (result.play_valid !== want.play_valid)
          note_mismatch($sformatf("play_valid %b, wanted %b", result.play_valid,
                                  want.play_valid));
        if (result.play_value !== want.play_value)
          note_mismatch($sformatf("play_value %h, wanted %h", result.play_value,
                                  want.play_value));
        if (result.table_full !== want.table_full)
          note_mismatch($sformatf("table_full %b, wanted %b", result.table_full,
                                  want.table_full));
      end
    end
  end

  // Hand-picked words: fetch with nothing playing, an empty table, zero as a
  // code, the table filling to its last slot and then refusing a new code,
  // and record and clear while playback is running.
  task automatic test_directed();
    send_word(OP_FETCH, 8'hFF);
    send_word(OP_START, 8'h00);
    send_word(OP_FETCH, 8'h00);
    send_word(OP_RECORD, 8'h00);
    send_word(OP_RECORD, 8'h00);
    // The zero run sits in an entry whose code is zero, so this overwrites it.
    send_word(OP_RECORD, 8'hAA);
    send_word(OP_RECORD, 8'h55);
    for (int i = 1; i <= DEPTH - 3; i++) send_word(OP_RECORD, CODE_BITS'(i));
    // The last slot takes a zero code; it still counts as in use.
    send_word(OP_RECORD, 8'h00);
    send_word(OP_RECORD, 8'hFF);
    send_word(OP_RECORD, 8'h00);
    send_word(OP_START, 8'hC3);
    send_word(OP_FETCH, 8'h3C);
    send_word(OP_FETCH, 8'h00);
    send_word(OP_RECORD, 8'h7E);
    send_word(OP_CLEAR, 8'hFF);
    send_word(OP_FETCH, 8'h00);
  endtask

  // Mostly well-formed sessions: bursts of runs, playbacks followed to
  // their end, and clears, with some loose words thrown in.
  task automatic test_random_sessions();
    int unsigned goal;
    int          runs;
    int          len;
    int          n;
    logic [CODE_BITS-1:0] v;
    goal = words_sent + RANDOM_WORDS;
    while (words_sent < goal) begin
      idle_on = ($urandom_range(0, 4) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // Now and then enough runs to overflow the table.
          runs = ($urandom_range(0, 4) == 0) ? $urandom_range(12, 20) : $urandom_range(1, 5);
          repeat (runs) begin
            v   = pick_code();
            len = $urandom_range(1, 4);
            repeat (len) send_word(OP_RECORD, v);
          end
        end
        4, 5, 6: begin
          send_word(OP_START, pick_code());
          n = 0;
          while (replay_on && n < 80) begin
            case ($urandom_range(0, 19))
              0:       send_word(OP_RECORD, pick_code());
              1:       send_word(OP_START, pick_code());
              default: send_word(OP_FETCH, pick_code());
            endcase
            n++;
          end
          repeat ($urandom_range(0, 2)) send_word(OP_FETCH, pick_code());
        end
        7: send_word(OP_CLEAR, pick_code());
        default: begin
          repeat ($urandom_range(1, 4))
            send_word(OP_BITS'($urandom_range(0, 3)), CODE_BITS'($urandom_range(0, 255)));
        end
      endcase
    end
    idle_on = 1'b1;
  endtask

  // The receiver stops for a long while; the sender keeps pushing words
  // back to back until the block can take no more.
  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_request = 300;
    send_word(OP_START, 8'h00);
    repeat (40) begin
      if ($urandom_range(0, 1) == 0) send_word(OP_RECORD, pick_code());
      else send_word(OP_FETCH, pick_code());
    end
    idle_on = 1'b1;
  endtask

  // Drives one long run followed by a single other code, then replays it:
  // the other code must show up on the fetch just past the end of the run.
  task automatic test_long_run();
    idle_on = 1'b0;
    send_word(OP_CLEAR, 8'h00);
    repeat (LONG_RUN) send_word(OP_RECORD, 8'h3C);
    send_word(OP_RECORD, 8'hC3);
    send_word(OP_START, 8'h00);
    repeat (LONG_RUN + 2) send_word(OP_FETCH, 8'h00);
    idle_on = 1'b1;
  endtask

  initial begin
    table_reset();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_sessions();
    test_backpressure();
    test_long_run();

    park_sender();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[run_length_record_replay_top] OK");
    end else begin
      $display("[run_length_record_replay_top] ERROR");
    end
    $finish;
  end

endmodule
